[src/ltrt_pkg.sv]
`default_nettype none
package ltrt_pkg;

    localparam int LANES          = 4;
    localparam int MIN_SPEED_CM_S = 100;

    // wheel speed is kept in Q14 cm/s (Q10.6 rad/s times Q8.8 cm)
    localparam logic [32:0] MIN_SPEED_Q14 = 33'(MIN_SPEED_CM_S * 16384);
    localparam logic [15:0] MIN_SPEED_U16 = 16'(MIN_SPEED_CM_S);
    localparam logic [15:0] SLIP_ONE      = 16'd256;
    localparam logic [16:0] FULL_PROGRESS = 17'h10000;
    localparam logic [15:0] THROTTLE_FULL = 16'hFFFF;

    localparam logic [1:0] REQ_TICK       = 2'd0;
    localparam logic [1:0] REQ_ACTIVATE   = 2'd1;
    localparam logic [1:0] REQ_DEACTIVATE = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACTION_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_RED  = 3'd4;

    localparam logic [15:0] RST_INIT_LIMIT  = 16'd19661;
    localparam logic [31:0] RST_RAMP_RATE   = 32'd2147;
    localparam logic        RST_TRACTION_EN = 1'b1;
    localparam logic [15:0] RST_SLIP_THR    = 16'd51;
    localparam logic [15:0] RST_TORQUE_RED  = 16'd19661;

    // stage strobes shared by the lanes and the merge stage
    typedef struct packed {
        logic mul;
        logic cmp;
        logic merge;
    } t_stage_ctrl;

endpackage
`default_nettype wire

[src/ltrt_lane.sv]
`default_nettype none
module ltrt_lane import ltrt_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_stage_ctrl        i_ctrl,
    input  wire logic signed [15:0] i_vehicle_speed,
    input  wire logic signed [15:0] i_ang_vel,
    input  wire logic        [15:0] i_radius,
    input  wire logic        [15:0] i_slip_threshold,
    output logic                    o_slip
);

    logic signed [32:0] r_wq;
    logic        [31:0] r_thrv;
    logic               r_slow;
    logic               r_slip;

    logic        [15:0] w_vmag;
    logic signed [33:0] w_vq;
    logic signed [33:0] w_diff;
    logic        [33:0] w_dmag;
    logic        [32:0] w_wmag;

    assign w_vmag = i_vehicle_speed[15] ? (~i_vehicle_speed + 16'd1) : i_vehicle_speed;
    assign w_vq   = {{4{i_vehicle_speed[15]}}, i_vehicle_speed, 14'd0};
    assign w_diff = {r_wq[32], r_wq} - w_vq;
    assign w_dmag = w_diff[33] ? (~w_diff + 34'd1) : w_diff;
    assign w_wmag = r_wq[32] ? (~r_wq + 33'd1) : r_wq;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_wq   <= i_ang_vel * $signed({1'b0, i_radius});
            r_thrv <= i_slip_threshold * w_vmag;
            r_slow <= w_vmag < MIN_SPEED_U16;
        end
        if (i_ctrl.cmp) begin
            if (r_slow) begin
                // slow vehicle: slip ratio is one when the wheel spins, else zero
                r_slip <= (w_wmag > MIN_SPEED_Q14) && (i_slip_threshold < SLIP_ONE);
            end else begin
                // |diff|*256 > thr*|v|*16384  <=>  |diff| > thr*|v|*64
                r_slip <= {4'd0, w_dmag} > {r_thrv, 6'd0};
            end
        end
    end

    assign o_slip = r_slip;

endmodule
`default_nettype wire

[src/ltrt_merge.sv]
`default_nettype none
module ltrt_merge import ltrt_pkg::*; (
    input  wire logic               i_clk,
    input  wire t_stage_ctrl        i_ctrl,
    input  wire logic [LANES-1:0]   i_slips,
    input  wire logic signed [15:0] i_engine_torque,
    input  wire logic        [15:0] i_torque_reduction,
    input  wire logic               i_traction_enable,
    output logic        [LANES-1:0] o_slip_mask,
    output logic signed [15:0]      o_reduced_torque
);

    logic signed [33:0]      r_prod;
    logic        [LANES-1:0] r_mask;
    logic signed [15:0]      r_red;

    logic [16:0]      w_keep;
    logic [LANES-1:0] w_mask;

    assign w_keep = FULL_PROGRESS - {1'b0, i_torque_reduction};
    assign w_mask = i_traction_enable ? i_slips : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= i_engine_torque * $signed({1'b0, w_keep});
        end
        if (i_ctrl.merge) begin
            r_mask <= w_mask;
            // arithmetic shift floors toward minus infinity
            r_red  <= (|w_mask) ? r_prod[31:16] : 16'sd0;
        end
    end

    assign o_slip_mask      = r_mask;
    assign o_reduced_torque = r_red;

endmodule
`default_nettype wire

[src/launch_throttle_ramp_traction.sv]
// A sequencer handles one item at a time in four steps (two partial products of the ramp
// step, clamp, throttle blend) and takes no new item until the result is written; the blend
// step waits while the result register still holds a result that was not taken.
// Four wheel lanes run in parallel with the ramp path; the result register frees the
// sequencer, so the next item is taken while a result waits. Config writes are always accepted.
// Reset (synchronous, active low): inactive, progress and throttle 0, registers defaults.
`default_nettype none
module launch_throttle_ramp_traction import ltrt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [19:0]          i_delta_time,
    input  wire logic signed [15:0]   i_vehicle_speed,
    input  wire logic signed [15:0]   i_engine_torque,
    input  wire logic signed [15:0]   i_wheel0_ang_vel,
    input  wire logic signed [15:0]   i_wheel1_ang_vel,
    input  wire logic signed [15:0]   i_wheel2_ang_vel,
    input  wire logic signed [15:0]   i_wheel3_ang_vel,
    input  wire logic [15:0]          i_wheel0_radius,
    input  wire logic [15:0]          i_wheel1_radius,
    input  wire logic [15:0]          i_wheel2_radius,
    input  wire logic [15:0]          i_wheel3_radius,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_is_active,
    output logic                      o_throttle_valid,
    output logic [15:0]               o_throttle_out,
    output logic                      o_ramp_done,
    output logic [3:0]                o_slip_mask,
    output logic signed [15:0]        o_reduced_torque,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MUL0, S_MUL1, S_SUM, S_BLEND} t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_init_limit;
    logic [31:0] r_ramp_rate;
    logic        r_traction_en;
    logic [15:0] r_slip_thr;
    logic [15:0] r_torque_red;

    // architectural state
    logic        r_active;
    logic [16:0] r_prog;
    logic [15:0] r_thr;

    // captured item and datapath
    logic [1:0]         r_req;
    logic [19:0]        r_dt;
    logic signed [15:0] r_veh;
    logic signed [15:0] r_torque;
    logic signed [15:0] r_ang [LANES];
    logic [15:0]        r_rad [LANES];
    logic [35:0]        r_pp_lo;
    logic [35:0]        r_step;
    logic [16:0]        r_p;

    // result register
    logic               r_out_valid;
    logic               r_o_active;
    logic               r_o_tvalid;
    logic [15:0]        r_o_thr;
    logic               r_o_done;
    logic [3:0]         r_o_mask;
    logic signed [15:0] r_o_red;

    logic        n_active;
    logic [16:0] n_prog;
    logic [15:0] n_thr;
    logic        n_tvalid;
    logic        n_done;
    logic        n_keep_mask;

    t_stage_ctrl        w_ctrl;
    logic [LANES-1:0]   w_slips;
    logic [LANES-1:0]   w_mask;
    logic signed [15:0] w_red;
    logic [36:0]        w_sum;
    logic [15:0]        w_room;
    logic [32:0]        w_blend_prod;
    logic [15:0]        w_blend;
    logic               w_finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_finish    = (r_state == S_BLEND) && (!r_out_valid || i_out_ready);

    assign w_ctrl.mul   = (r_state == S_MUL0);
    assign w_ctrl.cmp   = (r_state == S_MUL1);
    assign w_ctrl.merge = (r_state == S_SUM);

    assign w_sum        = {20'd0, r_prog} + {1'b0, r_step};
    assign w_room       = THROTTLE_FULL - r_init_limit;
    assign w_blend_prod = w_room * r_p;
    assign w_blend      = r_init_limit + w_blend_prod[31:16];

    always_comb begin
        n_active    = r_active;
        n_prog      = r_prog;
        n_thr       = r_thr;
        n_tvalid    = 1'b0;
        n_done      = 1'b0;
        n_keep_mask = 1'b0;
        unique case (r_req)
            REQ_ACTIVATE: begin
                n_active = 1'b1;
                n_prog   = '0;
                n_thr    = r_init_limit;
            end
            REQ_DEACTIVATE: begin
                n_active = 1'b0;
                n_thr    = '0;
            end
            REQ_TICK: begin
                if (r_active) begin
                    n_prog      = r_p;
                    n_thr       = w_blend;
                    n_tvalid    = 1'b1;
                    n_done      = r_p[16];
                    n_keep_mask = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_init_limit  <= RST_INIT_LIMIT;
            r_ramp_rate   <= RST_RAMP_RATE;
            r_traction_en <= RST_TRACTION_EN;
            r_slip_thr    <= RST_SLIP_THR;
            r_torque_red  <= RST_TORQUE_RED;
            r_active      <= 1'b0;
            r_prog        <= '0;
            r_thr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INIT_LIMIT:  r_init_limit  <= i_cfg_data[15:0];
                    CFG_RAMP_RATE:   r_ramp_rate   <= i_cfg_data;
                    CFG_TRACTION_EN: r_traction_en <= i_cfg_data[0];
                    CFG_SLIP_THR:    r_slip_thr    <= i_cfg_data[15:0];
                    CFG_TORQUE_RED:  r_torque_red  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0:  r_state <= S_MUL1;
                S_MUL1:  r_state <= S_SUM;
                S_SUM:   r_state <= S_BLEND;
                S_BLEND: begin
                    if (w_finish) begin
                        r_active    <= n_active;
                        r_prog      <= n_prog;
                        r_thr       <= n_thr;
                        r_o_active  <= n_active;
                        r_o_tvalid  <= n_tvalid;
                        r_o_thr     <= n_thr;
                        r_o_done    <= n_done;
                        r_o_mask    <= n_keep_mask ? w_mask : 4'd0;
                        r_o_red     <= n_keep_mask ? w_red : 16'sd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req    <= i_req_type;
            r_dt     <= i_delta_time;
            r_veh    <= i_vehicle_speed;
            r_torque <= i_engine_torque;
            r_ang[0] <= i_wheel0_ang_vel;
            r_ang[1] <= i_wheel1_ang_vel;
            r_ang[2] <= i_wheel2_ang_vel;
            r_ang[3] <= i_wheel3_ang_vel;
            r_rad[0] <= i_wheel0_radius;
            r_rad[1] <= i_wheel1_radius;
            r_rad[2] <= i_wheel2_radius;
            r_rad[3] <= i_wheel3_radius;
        end
        // ramp step: 20x32 product split into two 20x16 partial products
        if (w_ctrl.mul) begin
            r_pp_lo <= r_dt * r_ramp_rate[15:0];
        end
        if (w_ctrl.cmp) begin
            r_step <= (r_dt * r_ramp_rate[31:16]) + {16'd0, r_pp_lo[35:16]};
        end
        if (w_ctrl.merge) begin
            r_p <= (w_sum > {20'd0, FULL_PROGRESS}) ? FULL_PROGRESS : w_sum[16:0];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ltrt_lane u_lane (
            .i_clk           (i_clk),
            .i_ctrl          (w_ctrl),
            .i_vehicle_speed (r_veh),
            .i_ang_vel       (r_ang[g]),
            .i_radius        (r_rad[g]),
            .i_slip_threshold(r_slip_thr),
            .o_slip          (w_slips[g])
        );
    end

    ltrt_merge u_merge (
        .i_clk             (i_clk),
        .i_ctrl            (w_ctrl),
        .i_slips           (w_slips),
        .i_engine_torque   (r_torque),
        .i_torque_reduction(r_torque_red),
        .i_traction_enable (r_traction_en),
        .o_slip_mask       (w_mask),
        .o_reduced_torque  (w_red)
    );

    assign o_out_valid      = r_out_valid;
    assign o_is_active      = r_o_active;
    assign o_throttle_valid = r_o_tvalid;
    assign o_throttle_out   = r_o_thr;
    assign o_ramp_done      = r_o_done;
    assign o_slip_mask      = r_o_mask;
    assign o_reduced_torque = r_o_red;

endmodule
`default_nettype wire

[src/ltrt_checker.sv]
`default_nettype none
module ltrt_checker import ltrt_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic                 o_is_active,
    input wire logic                 o_throttle_valid,
    input wire logic [15:0]          o_throttle_out,
    input wire logic                 o_ramp_done,
    input wire logic [3:0]           o_slip_mask,
    input wire logic signed [15:0]   o_reduced_torque
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_throttle_valid |-> o_slip_mask == 4'd0 && !o_ramp_done)
        else $error("slip or done flagged without applied throttle");

    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ramp_done |-> o_throttle_out == THROTTLE_FULL)
        else $error("ramp done but throttle not full");

    a_no_slip_no_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slip_mask == 4'd0 |-> o_reduced_torque == 16'sd0)
        else $error("torque reduced with no slipping wheel");

    a_tick_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_throttle_valid |-> o_is_active)
        else $error("throttle applied while inactive");

endmodule

bind launch_throttle_ramp_traction ltrt_checker u_ltrt_checker (.*);
`default_nettype wire

[dv/testbench.sv]
module testbench;
    import ltrt_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [1:0]        req;
        logic [19:0]       dt;
        logic signed [15:0] veh;
        logic signed [15:0] trq;
        logic [3:0][15:0]  ang;
        logic [3:0][15:0]  rad;
    } launch_event_t;

    typedef struct packed {
        logic              is_active;
        logic              throttle_valid;
        logic [15:0]       throttle_out;
        logic              ramp_done;
        logic [3:0]        slip_mask;
        logic signed [15:0] reduced_torque;
    } launch_out_t;

    class launch_scoreboard;
        logic [15:0]   init_limit  = RST_INIT_LIMIT;
        logic [31:0]   ramp_rate   = RST_RAMP_RATE;
        logic          traction_en = RST_TRACTION_EN;
        logic [15:0]   slip_thr    = RST_SLIP_THR;
        logic [15:0]   torque_cut  = RST_TORQUE_RED;
        logic          active      = 1'b0;
        logic [16:0]   progress    = '0;
        logic [15:0]   throttle    = '0;
        launch_out_t   launch_outputs_q[$];
        int            errors      = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_INIT_LIMIT:  init_limit  = data[15:0];
                CFG_RAMP_RATE:   ramp_rate   = data;
                CFG_TRACTION_EN: traction_en = data[0];
                CFG_SLIP_THR:    slip_thr    = data[15:0];
                CFG_TORQUE_RED:  torque_cut  = data[15:0];
                default: ;
            endcase
        endfunction

        // slip ratio against threshold by cross-multiplying, speeds in Q14 cm/s
        function bit wheel_slipping(int veh, int ang, int rad);
            longint wq, vmag, wmag, diff, lhs, rhs;
            int thr, slip;
            thr  = slip_thr;
            wq   = longint'(ang) * longint'(rad);
            vmag = (veh < 0) ? -longint'(veh) : longint'(veh);
            if (vmag < longint'(MIN_SPEED_CM_S)) begin
                wmag = (wq < 0) ? -wq : wq;
                slip = (wmag > longint'(MIN_SPEED_CM_S) * 16384) ? int'(SLIP_ONE) : 0;
                return slip > thr;
            end
            diff = wq - longint'(veh) * 16384;
            lhs  = ((diff < 0) ? -diff : diff) * 256;
            rhs  = longint'(thr) * vmag * 16384;
            return lhs > rhs;
        endfunction

        // floor of torque * (1 - cut)
        function logic [15:0] cut_torque(int t);
            longint p;
            p = longint'(t) * (longint'(65536) - longint'(torque_cut));
            return 16'(p >>> 16);
        endfunction

        function launch_out_t advance_launch(launch_event_t ev);
            launch_out_t r;
            longint unsigned prog;
            int i, veh, ang, rad;
            r = '0;
            case (ev.req)
                REQ_ACTIVATE: begin
                    active   = 1'b1;
                    progress = '0;
                    throttle = init_limit;
                end
                REQ_DEACTIVATE: begin
                    active   = 1'b0;
                    throttle = '0;
                end
                REQ_TICK: if (active) begin
                    prog = 64'(progress) + ((64'(ev.dt) * 64'(ramp_rate)) >> 16);
                    if (prog > 64'(FULL_PROGRESS))
                        prog = 64'(FULL_PROGRESS);
                    progress = 17'(prog);
                    throttle = init_limit
                             + 16'((64'(THROTTLE_FULL - init_limit) * prog) >> 16);
                    r.throttle_valid = 1'b1;
                    r.ramp_done = (progress >= FULL_PROGRESS);
                    if (traction_en) begin
                        veh = ev.veh;
                        for (i = 0; i < LANES; i++) begin
                            ang = $signed(ev.ang[i]);
                            rad = ev.rad[i];
                            if (wheel_slipping(veh, ang, rad))
                                r.slip_mask[i] = 1'b1;
                        end
                        if (r.slip_mask != 4'd0)
                            r.reduced_torque = cut_torque(int'(ev.trq));
                    end
                end
                default: ;
            endcase
            r.is_active    = active;
            r.throttle_out = throttle;
            return r;
        endfunction

        function void note_event(launch_event_t ev);
            launch_outputs_q.push_back(advance_launch(ev));
        endfunction

        function void show(string tag, launch_out_t r);
            $display("  %s act=%0d tv=%0d thr=%0d done=%0d mask=%h torque=%0d", tag,
                     r.is_active, r.throttle_valid, r.throttle_out, r.ramp_done,
                     r.slip_mask, $signed(r.reduced_torque));
        endfunction

        function void check_output(launch_out_t got);
            launch_out_t want;
            if (launch_outputs_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("output transaction with nothing pending");
                    show("got", got);
                end
                return;
            end
            want = launch_outputs_q.pop_front();
            if (want.is_active !== got.is_active || want.throttle_valid !== got.throttle_valid
                || want.throttle_out !== got.throttle_out || want.ramp_done !== got.ramp_done
                || want.slip_mask !== got.slip_mask
                || want.reduced_torque !== got.reduced_torque) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch on output transaction");
                    show("exp", want);
                    show("got", got);
                end
            end
        endfunction

        function int pending();
            return launch_outputs_q.size();
        endfunction

        function bit failed();
            return (errors != 0) || (launch_outputs_q.size() != 0);
        endfunction
    endclass

    logic                 i_clk     = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    launch_event_t        stim      = '0;
    bit                   quiet     = 1'b0;
    bit                   hold_off  = 1'b0;
    int                   stall_cycles = 0;

    wire                  o_in_ready, o_out_valid, o_cfg_ready;
    wire                  o_is_active, o_throttle_valid, o_ramp_done;
    wire [15:0]           o_throttle_out;
    wire [3:0]            o_slip_mask;
    wire signed [15:0]    o_reduced_torque;
    launch_out_t          dut_out;

    launch_scoreboard     sb;

    assign dut_out = {o_is_active, o_throttle_valid, o_throttle_out, o_ramp_done,
                      o_slip_mask, o_reduced_torque};

    always #6 i_clk = ~i_clk;

    launch_throttle_ramp_traction dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (stim.req),
        .i_delta_time     (stim.dt),
        .i_vehicle_speed  (stim.veh),
        .i_engine_torque  (stim.trq),
        .i_wheel0_ang_vel (stim.ang[0]),
        .i_wheel1_ang_vel (stim.ang[1]),
        .i_wheel2_ang_vel (stim.ang[2]),
        .i_wheel3_ang_vel (stim.ang[3]),
        .i_wheel0_radius  (stim.rad[0]),
        .i_wheel1_radius  (stim.rad[1]),
        .i_wheel2_radius  (stim.rad[2]),
        .i_wheel3_radius  (stim.rad[3]),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_is_active      (o_is_active),
        .o_throttle_valid (o_throttle_valid),
        .o_throttle_out   (o_throttle_out),
        .o_ramp_done      (o_ramp_done),
        .o_slip_mask      (o_slip_mask),
        .o_reduced_torque (o_reduced_torque),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // inputs noted before outputs checked, both from pre-edge values
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && o_in_ready)
                sb.note_event(stim);
            if (o_out_valid && out_ready)
                sb.check_output(dut_out);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || (cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // output side: random back-pressure plus an occasional long hold-off
    initial begin
        forever begin
            if (hold_off) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic launch_event_t item_of(logic [1:0] req, int dt, int veh, int trq,
                                              int ang, int rad);
        launch_event_t ev;
        ev.req = req;
        ev.dt  = 20'(dt);
        ev.veh = 16'(veh);
        ev.trq = 16'(trq);
        for (int i = 0; i < 4; i++) begin
            ev.ang[i] = 16'(ang);
            ev.rad[i] = 16'(rad);
        end
        return ev;
    endfunction

    function automatic launch_event_t random_event();
        launch_event_t ev;
        int pick, v, r;
        longint base, w;
        pick = int'($urandom_range(0, 99));
        ev.req = (pick < 8)  ? REQ_ACTIVATE :
                 (pick < 15) ? REQ_DEACTIVATE :
                 (pick < 18) ? REQ_UNKNOWN : REQ_TICK;
        case ($urandom_range(0, 3))
            0:       ev.dt = 20'($urandom_range(0, 15));
            1:       ev.dt = 20'($urandom_range(0, 4095));
            2:       ev.dt = 20'($urandom_range(0, 65535));
            default: ev.dt = 20'($urandom());
        endcase
        case ($urandom_range(0, 2))
            0:       v = int'($urandom_range(0, 199)) - 100;
            1:       v = int'($urandom_range(100, 3000)) * ($urandom_range(0, 1) ? 1 : -1);
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        ev.veh = 16'(v);
        ev.trq = 16'($urandom());
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 1)) begin
                // wheel near the vehicle speed, within about +-40 percent
                r    = int'($urandom_range(1024, 65535));
                base = longint'(v) * 16384 / r;
                w    = base + base * (int'($urandom_range(0, 80)) - 40) / 100
                     + int'($urandom_range(0, 4)) - 2;
                if (w > 32767)
                    w = 32767;
                if (w < -32768)
                    w = -32768;
                ev.rad[i] = 16'(r);
                ev.ang[i] = 16'(w);
            end else begin
                ev.rad[i] = 16'($urandom());
                ev.ang[i] = 16'($urandom());
            end
        end
        return ev;
    endfunction

    task automatic send_event(input launch_event_t ev);
        stim     <= ev;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [15:0] init, input logic [31:0] rate,
                                  input logic te, input logic [15:0] thr,
                                  input logic [15:0] cut);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [31:0]          vals [5];
        idx  = '{CFG_INIT_LIMIT, CFG_RAMP_RATE, CFG_TRACTION_EN, CFG_SLIP_THR, CFG_TORQUE_RED};
        vals = '{32'(init), rate, 32'(te), 32'(thr), 32'(cut)};
        for (int r = 0; r < 5; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.write_reg(idx[r], vals[r]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int hold_at, input int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == hold_at)
                hold_off = 1'b1;
            send_event(random_event());
            if (k == pause_at)
                drain_outputs();
            else
                idle_gap();
        end
        drain_outputs();
    endtask

    initial begin
        launch_event_t seq[$];
        launch_event_t ev;
        logic [15:0]   s_init, s_thr, s_cut;
        logic [31:0]   s_rate;
        logic          s_te;

        sb = new();
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed events at reset settings
        seq.push_back(item_of(REQ_TICK, 1000, 500, 100, 1000, 7680));      // idle tick
        seq.push_back(item_of(REQ_UNKNOWN, 1048575, 500, 100, 1000, 7680));
        seq.push_back(item_of(REQ_DEACTIVATE, 0, 0, 0, 0, 0));
        seq.push_back(item_of(REQ_ACTIVATE, 0, 0, 0, 0, 0));
        seq.push_back(item_of(REQ_TICK, 0, 0, 0, 0, 0));
        seq.push_back(item_of(REQ_TICK, 100, 0, -32768, 32767, 65535));    // slow, wheel spins
        ev = item_of(REQ_TICK, 100, 99, 1000, 6400, 256);                   // wheel at 100 cm/s
        ev.ang[1] = 16'(6401);
        seq.push_back(ev);
        ev = item_of(REQ_TICK, 100, 100, -1000, 6400, 256);                 // ratio near threshold
        ev.ang[1] = 16'(7680);
        ev.ang[2] = 16'(7616);
        ev.ang[3] = 16'(-6400);
        seq.push_back(ev);
        ev = item_of(REQ_TICK, 100, -100, 32767, -6400, 256);
        ev.ang[1] = 16'(0);
        ev.rad[2] = 16'(0);
        seq.push_back(ev);
        seq.push_back(item_of(REQ_TICK, 3000, -32768, -1, -32768, 65535));
        seq.push_back(item_of(REQ_TICK, 3000, 32767, -32768, 32767, 65535));
        ev = item_of(REQ_TICK, 1048575, -99, -32767, -6400, 256);           // maximum delta time, ramp not yet full
        ev.ang[0] = 16'(-6401);
        seq.push_back(ev);
        seq.push_back(item_of(REQ_TICK, 5, 200, 12345, 3200, 1024));
        seq.push_back(item_of(REQ_ACTIVATE, 1048575, -1, -1, -1, 65535));   // restart
        seq.push_back(item_of(REQ_UNKNOWN, 1000, 500, 100, 1000, 7680));
        seq.push_back(item_of(REQ_TICK, 1, 500, 100, 1000, 7680));
        seq.push_back(item_of(REQ_TICK, 1048575, -32768, 32767, 0, 0));
        seq.push_back(item_of(REQ_DEACTIVATE, 1048575, -1, -1, -1, 65535));
        seq.push_back(item_of(REQ_TICK, 1048575, 0, -32768, 32767, 65535));
        seq.push_back(item_of(REQ_DEACTIVATE, 0, 0, 0, 0, 0));
        seq.push_back(item_of(REQ_ACTIVATE, 0, 0, 0, 0, 0));
        seq.push_back(item_of(REQ_TICK, 30000, -99, 0, 0, 0));
        foreach (seq[j]) begin
            send_event(seq[j]);
            idle_gap();
        end
        drain_outputs();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    s_init = 16'd0;     s_rate = 32'd1;
                    s_te   = 1'b1;      s_thr  = 16'd0;     s_cut = 16'd0;
                end
                1: begin
                    s_init = 16'hFFFF;  s_rate = 32'hFFFF_FFFF;
                    s_te   = 1'b1;      s_thr  = 16'hFFFF;  s_cut = 16'hFFFF;
                end
                default: begin
                    s_init = 16'($urandom());
                    case ($urandom_range(0, 2))
                        0:       s_rate = 32'($urandom_range(1, 255));
                        1:       s_rate = 32'($urandom_range(256, 1 << 20));
                        default: s_rate = $urandom() | 32'd1;
                    endcase
                    s_te  = (p == 2 || p == 5) ? 1'b0 : 1'b1;
                    s_thr = $urandom_range(0, 1) ? 16'($urandom_range(0, 600))
                                                 : 16'($urandom());
                    s_cut = 16'($urandom());
                end
            endcase
            write_settings(s_init, s_rate, s_te, s_thr, s_cut);
            quiet = (p == 7);
            run_phase(240, (p == 3) ? 60 : -1, (p == 4) ? 120 : -1);
        end

        repeat (20) @(posedge i_clk);
        if (!sb.failed())
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
